>>> design/mma_pkg.sv
// ============================================================================
// mma_pkg: shared types and constants for the 128-bit modular arithmetic unit
// Function codes, register indexes, widths and the item record that travels
// down the pipeline.
// ============================================================================
package mma_pkg;

    localparam int HALF_W = 64;
    localparam int WORD_W = 128;
    localparam int ACC_W  = 194;   // a*d + acc + q*n stays below 2^194
    localparam int V_W    = 130;   // accumulator after the 64-bit shift
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Function codes.
    localparam logic [1:0] FN_MONT    = 2'd0;
    localparam logic [1:0] FN_MONT_NS = 2'd1;
    localparam logic [1:0] FN_ADD     = 2'd2;
    localparam logic [1:0] FN_NEG     = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_N_LO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_N_HI    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_INV = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] acc;
    } t_item;

    // True for both Montgomery product functions.
    function automatic logic is_mont(input logic [1:0] func);
        is_mont = (func == FN_MONT) || (func == FN_MONT_NS);
    endfunction

endpackage

>>> design/mma_in_if.sv
// ============================================================================
// mma_in_if: operand channel
// Valid/ready channel carrying a function code and two 128-bit operands.
// ============================================================================
interface mma_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] b_lo;
    logic [63:0] b_hi;

    modport source (output valid, func, a_lo, a_hi, b_lo, b_hi, input ready);
    modport sink   (input valid, func, a_lo, a_hi, b_lo, b_hi, output ready);
endinterface

>>> design/mma_out_if.sv
// ============================================================================
// mma_out_if: result channel
// Valid/ready channel carrying one 128-bit result.
// ============================================================================
interface mma_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_lo;
    logic [63:0] result_hi;

    modport source (output valid, result_lo, result_hi, input ready);
    modport sink   (input valid, result_lo, result_hi, output ready);
endinterface

>>> design/mma_digit.sv
// ============================================================================
// mma_digit: one Montgomery digit step
// Seven register stages: a*digit partials, accumulate, q partials, q,
// q*n partials, accumulate and shift, conditional subtraction. Items of the
// other functions pass through with their result unchanged.
// ============================================================================
module mma_digit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_hi,
    input  logic [mma_pkg::WORD_W-1:0]    i_n,
    input  logic [mma_pkg::HALF_W-1:0]    i_neg_inv,
    input  logic                          i_vld,
    input  mma_pkg::t_item                i_item,
    output logic                          o_vld,
    output mma_pkg::t_item                o_item
);

    logic [6:0]                       r_vld;
    mma_pkg::t_item                   r_item [0:6];
    logic [63:0]                      r_pp1  [0:7];
    logic [63:0]                      r_pp2  [0:7];
    logic [mma_pkg::ACC_W-1:0]        r_acc1, r_acc2, r_acc3, r_acc4;
    logic [63:0]                      r_qll, r_qlh, r_qhl, r_q;
    logic [mma_pkg::V_W-1:0]          r_v;

    logic [63:0]                      w_digit;
    logic [mma_pkg::ACC_W-1:0]        w_sum1, w_sum2;
    logic [31:0]                      w_qmid;
    logic [mma_pkg::V_W-1:0]          w_vsub;
    logic                             w_sub;
    logic [mma_pkg::WORD_W-1:0]       w_acc6;

    assign w_digit = i_hi ? i_item.b[127:64] : i_item.b[63:0];

    // Sum of the partial products of each 128 x 64 multiplication.
    always_comb begin
        w_sum1 = r_item[0].acc;
        w_sum2 = r_acc4;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 2; j++) begin
                w_sum1 = w_sum1 + (mma_pkg::ACC_W'(r_pp1[i*2+j]) << (32*(i+j)));
                w_sum2 = w_sum2 + (mma_pkg::ACC_W'(r_pp2[i*2+j]) << (32*(i+j)));
            end
        end
    end

    assign w_qmid = r_qlh[31:0] + r_qhl[31:0];

    // Subtract n when the shifted sum reaches it, on every step but the last
    // step of the function without a final subtraction.
    assign w_vsub = r_v - mma_pkg::V_W'(i_n);
    assign w_sub  = mma_pkg::is_mont(r_item[5].func)
                    && (!i_hi || (r_item[5].func == mma_pkg::FN_MONT))
                    && (r_v >= mma_pkg::V_W'(i_n));

    // Montgomery items take the reduced sum; others keep their result.
    assign w_acc6 = !mma_pkg::is_mont(r_item[5].func) ? r_item[5].acc
                  : (w_sub ? w_vsub[127:0] : r_v[127:0]);

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < 6; k++) begin
                r_item[k] <= r_item[k-1];
            end
            r_item[6] <= {r_item[5].func, r_item[5].a, r_item[5].b, w_acc6};
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r_pp1[i*2+j] <= 64'(i_item.a[32*i +: 32]) * 64'(w_digit[32*j +: 32]);
                    r_pp2[i*2+j] <= 64'(i_n[32*i +: 32]) * 64'(r_q[32*j +: 32]);
                end
            end
            r_acc1 <= w_sum1;
            r_acc2 <= r_acc1;
            r_qll  <= 64'(r_acc1[31:0])  * 64'(i_neg_inv[31:0]);
            r_qlh  <= 64'(r_acc1[31:0])  * 64'(i_neg_inv[63:32]);
            r_qhl  <= 64'(r_acc1[63:32]) * 64'(i_neg_inv[31:0]);
            r_acc3 <= r_acc2;
            r_q    <= r_qll + {w_qmid, 32'h0};
            r_acc4 <= r_acc3;
            r_v    <= w_sum2[mma_pkg::V_W+63:64];
        end
    end

    assign o_vld  = r_vld[6];
    assign o_item = r_item[6];

`ifndef SYNTHESIS
    // Non-Montgomery items leave the step with the result they brought.
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] && $past(i_en) && !mma_pkg::is_mont(r_item[6].func)
        |-> r_item[6].acc == $past(r_item[5].acc))
        else $error("bypass item changed in digit step");
    // A stall freezes the whole valid line.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld))
        else $error("valid line moved during stall");
    // The line is empty right after reset.
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> r_vld == '0)
        else $error("valid left in line after reset");
`endif

endmodule

>>> design/montgomery_mod_arith_128.sv
// ============================================================================
// montgomery_mod_arith_128: pipelined 128-bit modular arithmetic unit
// Montgomery product (R = 2^128), modular add and negate, one result per item.
//
//   channel | dir | payload
//   i_in    | in  | func, a_lo, a_hi, b_lo, b_hi
//   o_out   | out | result_lo, result_hi
//   cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// The result passes through one entry stage and two seven-stage digit steps,
// 15 registers in all.
// One transaction is accepted per cycle while the output is not stalled.
// A stall on the output freezes the whole pipeline; nothing is lost.
// Reset clears the configuration registers and the pipeline valid bits.
// ============================================================================
module montgomery_mod_arith_128 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mma_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mma_in_if.sink                            i_in,
    mma_out_if.source                         o_out
);

    logic [63:0]            r_n_lo, r_n_hi, r_neg_inv;
    logic [127:0]           w_n;
    logic                   w_en;

    logic                   r_vld0;
    logic [1:0]             r_func0;
    logic [127:0]           r_a0, r_b0, r_neg0;
    logic [128:0]           r_sum0;
    logic [128:0]           w_sumsub;
    mma_pkg::t_item         w_item0;

    logic                   w_vld1, w_vld2;
    mma_pkg::t_item         w_item1, w_item2;

    assign w_n  = {r_n_hi, r_n_lo};
    assign w_en = !w_vld2 || o_out.ready;
    assign i_in.ready = w_en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_lo    <= '0;
            r_n_hi    <= '0;
            r_neg_inv <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mma_pkg::CFG_N_LO:    r_n_lo    <= i_cfg_data;
                mma_pkg::CFG_N_HI:    r_n_hi    <= i_cfg_data;
                mma_pkg::CFG_NEG_INV: r_neg_inv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Entry stage: register operands, form the sum and the negation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (w_en) begin
            r_vld0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_func0 <= i_in.func;
            r_a0    <= {i_in.a_hi, i_in.a_lo};
            r_b0    <= {i_in.b_hi, i_in.b_lo};
            r_sum0  <= 129'({i_in.a_hi, i_in.a_lo}) + 129'({i_in.b_hi, i_in.b_lo});
            r_neg0  <= w_n - {i_in.b_hi, i_in.b_lo};
        end
    end

    // Conditional subtraction for the modular add.
    assign w_sumsub = (r_sum0 >= 129'(w_n)) ? (r_sum0 - 129'(w_n)) : r_sum0;

    always_comb begin
        w_item0.func = r_func0;
        w_item0.a    = r_a0;
        w_item0.b    = r_b0;
        unique case (r_func0)
            mma_pkg::FN_ADD: w_item0.acc = w_sumsub[127:0];
            mma_pkg::FN_NEG: w_item0.acc = r_neg0;
            default:         w_item0.acc = '0;
        endcase
    end

    // Low digit of b, then high digit.
    mma_digit u_digit_lo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_hi      (1'b0),
        .i_n       (w_n),
        .i_neg_inv (r_neg_inv),
        .i_vld     (r_vld0),
        .i_item    (w_item0),
        .o_vld     (w_vld1),
        .o_item    (w_item1)
    );

    mma_digit u_digit_hi (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_hi      (1'b1),
        .i_n       (w_n),
        .i_neg_inv (r_neg_inv),
        .i_vld     (w_vld1),
        .i_item    (w_item1),
        .o_vld     (w_vld2),
        .o_item    (w_item2)
    );

    assign o_out.valid     = w_vld2;
    assign o_out.result_lo = w_item2.acc[63:0];
    assign o_out.result_hi = w_item2.acc[127:64];

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the 128-bit modular arithmetic unit
// A clocked driver feeds operand transactions from a queue, a clocked monitor
// checks each result against a bit-exact predictor of the Montgomery product,
// modular add and negate, over several modulus and constant settings.
// ============================================================================
module tb;

    typedef struct {
        logic [1:0]   func;
        logic [127:0] a;
        logic [127:0] b;
    } t_op;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [mma_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [mma_pkg::CFG_DATA_W-1:0] i_cfg_data;

    mma_in_if  in_ch ();
    mma_out_if out_ch ();

    montgomery_mod_arith_128 u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Shadow copy of the configuration registers.
    logic [127:0] shadow_n;
    logic [63:0]  shadow_ninv;

    t_op          op_queue[$];
    logic [127:0] result_queue[$];
    int           mismatches;
    int           idle_cycles;
    bit           no_idle;
    int           hold_req;
    int           hold_done;
    bit           in_fire;
    int           tx_gap;
    int           rx_gap;
    int           hold_cnt;

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Subtract the modulus once when the value is not below it.
    function automatic logic [191:0] reduce_once(logic [191:0] v, logic [127:0] n);
        if (v >= {64'd0, n}) begin
            return v - {64'd0, n};
        end
        return v;
    endfunction

    function automatic logic [127:0] mod_result(logic [1:0] func, logic [127:0] a,
                                                logic [127:0] b, logic [127:0] n,
                                                logic [63:0] ninv);
        logic [255:0] acc;
        logic [63:0]  digit;
        logic [63:0]  q;
        logic [191:0] v;
        acc = '0;
        case (func)
            mma_pkg::FN_MONT, mma_pkg::FN_MONT_NS: begin
                for (int j = 0; j < 2; j++) begin
                    digit = (j == 0) ? b[63:0] : b[127:64];
                    acc = acc + {192'd0, digit} * {128'd0, a};
                    q = acc[63:0] * ninv;
                    acc = acc + {192'd0, q} * {128'd0, n};
                    acc = acc >> 64;
                    if (j == 0 || func == mma_pkg::FN_MONT) begin
                        acc[191:0] = reduce_once(acc[191:0], n);
                    end
                    acc = {128'd0, acc[127:0]};
                end
                return acc[127:0];
            end
            mma_pkg::FN_ADD: begin
                v = {64'd0, a} + {64'd0, b};
                v = reduce_once(v, n);
                return v[127:0];
            end
            default: begin
                return n - b;
            end
        endcase
    endfunction

    // Newton iteration for -n^-1 mod 2^64 (n odd).
    function automatic logic [63:0] mont_const(logic [63:0] n0);
        logic [63:0] inv;
        inv = n0;
        for (int k = 0; k < 6; k++) begin
            inv = inv * (64'd2 - n0 * inv);
        end
        return -inv;
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 9) < 7) begin
            return 0;
        end
        if ($urandom_range(0, 19) != 0) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 60);
    endfunction

    // Sample operand transactions and record the predicted result.
    always @(posedge i_clk) begin
        in_fire <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready) begin
            result_queue.push_back(mod_result(in_ch.func, {in_ch.a_hi, in_ch.a_lo},
                                              {in_ch.b_hi, in_ch.b_lo},
                                              shadow_n, shadow_ninv));
        end
    end

    // Operand driver.
    always @(negedge i_clk) begin
        t_op op;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            tx_gap <= 0;
        end else if (!in_ch.valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                op = op_queue.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.func <= op.func;
                in_ch.a_lo <= op.a[63:0];
                in_ch.a_hi <= op.a[127:64];
                in_ch.b_lo <= op.b[63:0];
                in_ch.b_hi <= op.b[127:64];
                tx_gap <= pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls and a requested long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_gap <= 0;
            hold_cnt <= 0;
            hold_done <= 0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_cnt <= 400;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            rx_gap <= pick_gap();
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (out_ch.valid && out_ch.ready) begin
            if (result_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result %h_%h", out_ch.result_hi, out_ch.result_lo);
                end
            end else begin
                want = result_queue.pop_front();
                if (out_ch.result_lo !== want[63:0] || out_ch.result_hi !== want[127:64]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected hi %h lo %h, got hi %h lo %h",
                                 want[127:64], want[63:0], out_ch.result_hi,
                                 out_ch.result_lo);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 3000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [mma_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mma_pkg::CFG_N_LO:    shadow_n[63:0] = data;
            mma_pkg::CFG_N_HI:    shadow_n[127:64] = data;
            mma_pkg::CFG_NEG_INV: shadow_ninv = data;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [127:0] n, logic [63:0] ninv);
        write_reg(mma_pkg::CFG_N_LO, n[63:0]);
        write_reg(mma_pkg::CFG_N_HI, n[127:64]);
        write_reg(mma_pkg::CFG_NEG_INV, ninv);
        // Index beyond the register list must be ignored.
        write_reg(2'd3, {$urandom, $urandom});
    endtask

    task automatic add_op(logic [1:0] func, logic [127:0] a, logic [127:0] b);
        t_op op;
        op.func = func;
        op.a = a;
        op.b = b;
        op_queue.push_back(op);
    endtask

    function automatic logic [127:0] rand_word();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Random operand, reduced below the modulus most of the time.
    function automatic logic [127:0] rand_operand();
        logic [127:0] w;
        w = rand_word();
        if (shadow_n != 0 && $urandom_range(0, 3) != 0) begin
            w = w % shadow_n;
        end
        return w;
    endfunction

    task automatic wait_drained();
        while (op_queue.size() > 0 || in_ch.valid || result_queue.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
    endtask

    // Stimulus sequence: one phase per configuration setting.
    initial begin
        logic [127:0] n;
        logic [127:0] edge_vals[4];
        mismatches = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = mma_pkg::FN_MONT;
        in_ch.a_lo = '0;
        in_ch.a_hi = '0;
        in_ch.b_lo = '0;
        in_ch.b_hi = '0;
        out_ch.ready = 1'b0;
        shadow_n = '0;
        shadow_ninv = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    n = {$urandom, $urandom, $urandom, $urandom} | 128'd1;
                    set_config(n, mont_const(n[63:0]));
                end
                1: set_config('0, '0);
                2: set_config({128{1'b1}}, {64{1'b1}});
                3: begin
                    n = {64'd0, 32'd0, $urandom} | 128'd1;
                    set_config(n, mont_const(n[63:0]));
                end
                4: set_config(rand_word(), {$urandom, $urandom});
                default: begin
                    n = rand_word() | {1'b1, 126'd0, 1'b1};
                    set_config(n, mont_const(n[63:0]));
                end
            endcase

            // Directed extremes for every function.
            if (phase == 0 || phase == 2) begin
                edge_vals[0] = '0;
                edge_vals[1] = {128{1'b1}};
                edge_vals[2] = shadow_n - 128'd1;
                edge_vals[3] = shadow_n;
                for (int f = 0; f < 4; f++) begin
                    add_op(f[1:0], edge_vals[0], edge_vals[1]);
                    add_op(f[1:0], edge_vals[1], edge_vals[1]);
                    add_op(f[1:0], edge_vals[2], edge_vals[2]);
                end
            end

            // The receiver holds off while the sender keeps offering.
            if (phase == 1) begin
                hold_req++;
            end
            no_idle = (phase == 3);

            for (int k = 0; k < 175; k++) begin
                add_op(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
            end
            wait_drained();
        end

        if (mismatches == 0 && result_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
